>>> hdl/csvt_pkg.sv
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_FEND = 2'd1,
        K_ERR  = 2'd2,
        K_DISC = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        E_LINE_BREAK  = 2'd0,
        E_MISPLACED_Q = 2'd1,
        E_AFTER_CLOSE = 2'd2,
        E_UNTERM_Q    = 2'd3
    } t_err;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        t_err       err_code;
        logic       end_of_record;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_push;

    function automatic t_res mk_res(t_kind kind, logic [7:0] b, t_err code, logic eor);
        t_res r;
        r.kind          = kind;
        r.out_byte      = b;
        r.err_code      = code;
        r.end_of_record = eor;
        return r;
    endfunction

endpackage

>>> hdl/csvt_parse.sv
module csvt_parse
    import csvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_has_byte,
    input  logic       i_last,
    output t_push      o_push
);

    logic r_in_quotes, r_quote_pending, r_field_quoted, r_field_content, r_discarding;
    logic n_in_quotes, n_quote_pending, n_field_quoted, n_field_content, n_discarding;

    always_comb begin
        logic       done;
        logic       err_v;
        t_err       err_c;
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
        t_res       nr;
        logic       have_new;
        done            = 1'b0;
        err_v           = 1'b0;
        err_c           = E_LINE_BREAK;
        cnt             = 2'd0;
        r0              = '0;
        r1              = '0;
        nr              = '0;
        have_new        = 1'b0;
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_field_quoted  = r_field_quoted;
        n_field_content = r_field_content;
        n_discarding    = r_discarding;

        if (r_discarding) begin
            if (i_last) begin
                r0 = mk_res(K_DISC, 8'd0, E_LINE_BREAK, 1'b1);
                cnt = 2'd1;
                n_in_quotes     = 1'b0;
                n_quote_pending = 1'b0;
                n_field_quoted  = 1'b0;
                n_field_content = 1'b0;
                n_discarding    = 1'b0;
            end
        end else begin
            if (i_has_byte) begin
                if (r_quote_pending) begin
                    n_quote_pending = 1'b0;
                    if (i_byte == CH_QUOTE) begin
                        nr = mk_res(K_DATA, CH_QUOTE, E_LINE_BREAK, 1'b0);
                        have_new = 1'b1;
                        n_field_content = 1'b1;
                        done = 1'b1;
                    end else begin
                        n_in_quotes = 1'b0;
                    end
                end
                if (!done) begin
                    if (n_in_quotes) begin
                        if (i_byte == CH_QUOTE) begin
                            n_quote_pending = 1'b1;
                        end else begin
                            nr = mk_res(K_DATA, i_byte, E_LINE_BREAK, 1'b0);
                            have_new = 1'b1;
                            n_field_content = 1'b1;
                        end
                    end else if (i_byte == CH_CR || i_byte == CH_LF) begin
                        err_v = 1'b1;
                        err_c = E_LINE_BREAK;
                    end else if (i_byte == CH_QUOTE) begin
                        if (r_field_content) begin
                            err_v = 1'b1;
                            err_c = E_MISPLACED_Q;
                        end else begin
                            n_in_quotes    = 1'b1;
                            n_field_quoted = 1'b1;
                        end
                    end else if (i_byte == CH_COMMA) begin
                        nr = mk_res(K_FEND, 8'd0, E_LINE_BREAK, 1'b0);
                        have_new = 1'b1;
                        n_field_content = 1'b0;
                        n_field_quoted  = 1'b0;
                    end else if (r_field_quoted) begin
                        err_v = 1'b1;
                        err_c = E_AFTER_CLOSE;
                    end else begin
                        nr = mk_res(K_DATA, i_byte, E_LINE_BREAK, 1'b0);
                        have_new = 1'b1;
                        n_field_content = 1'b1;
                    end
                end
            end

            if (have_new) begin
                r0 = nr;
                cnt = 2'd1;
            end

            if (err_v) begin
                r0 = mk_res(K_ERR, 8'd0, err_c, i_last);
                cnt = 2'd1;
                n_in_quotes     = 1'b0;
                n_quote_pending = 1'b0;
                n_field_quoted  = 1'b0;
                n_field_content = 1'b0;
                n_discarding    = !i_last;
            end else if (i_last) begin
                if (n_in_quotes && !n_quote_pending) begin
                    nr = mk_res(K_ERR, 8'd0, E_UNTERM_Q, 1'b1);
                end else begin
                    nr = mk_res(K_FEND, 8'd0, E_LINE_BREAK, 1'b1);
                end
                if (cnt == 2'd0) begin
                    r0 = nr;
                end else begin
                    r1 = nr;
                end
                cnt = cnt + 2'd1;
                n_in_quotes     = 1'b0;
                n_quote_pending = 1'b0;
                n_field_quoted  = 1'b0;
                n_field_content = 1'b0;
                n_discarding    = 1'b0;
            end
        end

        o_push.count = i_accept ? cnt : 2'd0;
        o_push.res0  = r0;
        o_push.res1  = r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_field_quoted  <= 1'b0;
            r_field_content <= 1'b0;
            r_discarding    <= 1'b0;
        end else if (i_accept) begin
            r_in_quotes     <= n_in_quotes;
            r_quote_pending <= n_quote_pending;
            r_field_quoted  <= n_field_quoted;
            r_field_content <= n_field_content;
            r_discarding    <= n_discarding;
        end
    end

endmodule

>>> hdl/csvt_outq.sv
module csvt_outq
    import csvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop_ready,
    output logic       o_space,
    output logic       o_valid,
    output t_res       o_head,
    output logic [1:0] o_count
);

    t_res       r_q [3];
    logic [1:0] r_cnt;
    t_res       n_q [3];
    logic [1:0] n_cnt;

    always_comb begin
        logic       pop;
        logic [1:0] base;
        pop = (r_cnt != 2'd0) && i_pop_ready;
        n_q[0] = r_q[0];
        n_q[1] = r_q[1];
        n_q[2] = r_q[2];
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        base = r_cnt - {1'b0, pop};
        if (i_push.count != 2'd0) begin
            n_q[base] = i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            n_q[2'(base + 2'd1)] = i_push.res1;
        end
        n_cnt = base + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        r_q[2] <= n_q[2];
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_space = (r_cnt <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];
    assign o_count = r_cnt;

endmodule

>>> hdl/csv_field_tokenizer_core.sv
// csv field tokenizer: splits one record's bytes into unescaped field bytes,
// field-end marks and error reports.
// slave channel: one transfer per item; tdata is the byte, tuser says
// the byte is present (low for an item with no byte, such as an empty
// record's closing item), tlast marks the final item of the record.
// master channel: tuser is the result kind (data, field end, error, end of
// discarded record), tdata carries the byte and error code, tlast ends the
// record.
// the results of an item are registered in the result queue before they leave.
// throughput: one item per cycle while each item gives at most one result and
// the master is ready; two results from one item (a byte, then the closing
// result) drop tready until one drains. the rate is set by the three-entry
// result queue, which takes an item whenever it holds at most one result.
// reset: all parse flags clear and the result queue empties.
// stall: while the master side is held, the queue fills and the slave tready
// drops once two results wait; nothing is lost.
module csv_field_tokenizer_core
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] in_byte
    input  logic        i_s_axis_tuser,  // [0] has_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] out_byte, [9:8] err_code, rest zero
    output logic [1:0]  o_m_axis_tuser,  // [1:0] kind
    output logic        o_m_axis_tlast
);

    logic       accept;
    logic       space;
    t_push      push;
    t_res       head;
    logic [1:0] q_count;

    assign accept          = i_s_axis_tvalid && space;
    assign o_s_axis_tready = space;

    csvt_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_s_axis_tdata),
        .i_has_byte (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .o_push     (push)
    );

    csvt_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (i_m_axis_tready),
        .o_space     (space),
        .o_valid     (o_m_axis_tvalid),
        .o_head      (head),
        .o_count     (q_count)
    );

    assign o_m_axis_tdata = {6'd0, head.err_code, head.out_byte};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.end_of_record;

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> (q_count <= 2'd1))
        else $error("results pushed into a full queue");

    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == K_DATA) |-> !o_m_axis_tlast)
        else $error("data byte marked as end of record");

    a_code_only_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != K_ERR) |-> (o_m_axis_tdata[9:8] == 2'd0))
        else $error("error code on a non-error result");

    a_two_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (i_s_axis_tlast && push.res1.end_of_record))
        else $error("two results from an item that does not end the record");

endmodule

>>> verif/csvt_checker.sv
module csvt_checker
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] in_byte
    input  logic        i_s_tuser,  // [0] has_byte
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,  // [7:0] out_byte, [9:8] err_code, rest zero
    input  logic [1:0]  i_m_tuser,  // [1:0] kind
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_res expected_tokens[$];
    int   mismatches = 0;
    int   waiting = 0;

    logic quoted_open    = 1'b0;
    logic quote_held     = 1'b0;
    logic field_quoted   = 1'b0;
    logic field_nonempty = 1'b0;
    logic skip_rest      = 1'b0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic t_res token(t_kind k, logic [7:0] b, t_err c, logic eor);
        t_res r;
        r.kind          = k;
        r.out_byte      = b;
        r.err_code      = c;
        r.end_of_record = eor;
        return r;
    endfunction

    task automatic expect_token(input t_res r);
        expected_tokens.insert(expected_tokens.size(), r);
    endtask

    task automatic clear_flags();
        quoted_open    = 1'b0;
        quote_held     = 1'b0;
        field_quoted   = 1'b0;
        field_nonempty = 1'b0;
        skip_rest      = 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    // works out the results of one accepted item from the parse flags
    task automatic tokenize_item(input logic [7:0] b, input logic has, input logic last);
        logic settled;
        logic raise;
        t_err code;
        settled = 1'b0;
        raise   = 1'b0;
        code    = E_LINE_BREAK;
        if (skip_rest) begin
            if (last) begin
                expect_token(token(K_DISC, 8'h00, E_LINE_BREAK, 1'b1));
                clear_flags();
            end
            return;
        end
        if (has) begin
            // a held quote is either an escaped quote or the closing one
            if (quote_held) begin
                quote_held = 1'b0;
                if (b == CH_QUOTE) begin
                    expect_token(token(K_DATA, CH_QUOTE, E_LINE_BREAK, 1'b0));
                    field_nonempty = 1'b1;
                    settled = 1'b1;
                end else begin
                    quoted_open = 1'b0;
                end
            end
            if (!settled) begin
                if (quoted_open) begin
                    if (b == CH_QUOTE) begin
                        quote_held = 1'b1;
                    end else begin
                        expect_token(token(K_DATA, b, E_LINE_BREAK, 1'b0));
                        field_nonempty = 1'b1;
                    end
                end else if (b == CH_CR || b == CH_LF) begin
                    raise = 1'b1;
                    code  = E_LINE_BREAK;
                end else if (b == CH_QUOTE) begin
                    if (field_nonempty) begin
                        raise = 1'b1;
                        code  = E_MISPLACED_Q;
                    end else begin
                        quoted_open  = 1'b1;
                        field_quoted = 1'b1;
                    end
                end else if (b == CH_COMMA) begin
                    expect_token(token(K_FEND, 8'h00, E_LINE_BREAK, 1'b0));
                    field_nonempty = 1'b0;
                    field_quoted   = 1'b0;
                end else if (field_quoted) begin
                    raise = 1'b1;
                    code  = E_AFTER_CLOSE;
                end else begin
                    expect_token(token(K_DATA, b, E_LINE_BREAK, 1'b0));
                    field_nonempty = 1'b1;
                end
            end
        end
        if (raise) begin
            expect_token(token(K_ERR, 8'h00, code, last));
            clear_flags();
            skip_rest = !last;
            return;
        end
        if (last) begin
            if (quoted_open && !quote_held) begin
                expect_token(token(K_ERR, 8'h00, E_UNTERM_Q, 1'b1));
            end else begin
                expect_token(token(K_FEND, 8'h00, E_LINE_BREAK, 1'b1));
            end
            clear_flags();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            clear_flags();
            expected_tokens.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_tokens.size() == 0) begin
                    flag_mismatch("unexpected result, kind", -1, i_m_tuser);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_m_tuser != want.kind)
                        flag_mismatch("kind", want.kind, i_m_tuser);
                    if (i_m_tdata[7:0] != want.out_byte)
                        flag_mismatch("out_byte", want.out_byte, i_m_tdata[7:0]);
                    if (i_m_tdata[9:8] != want.err_code)
                        flag_mismatch("err_code", want.err_code, i_m_tdata[9:8]);
                    if (i_m_tlast != want.end_of_record)
                        flag_mismatch("end_of_record", want.end_of_record, i_m_tlast);
                    if (i_m_tdata[15:10] != 6'd0)
                        flag_mismatch("tdata padding", 0, i_m_tdata[15:10]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                tokenize_item(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        waiting <= expected_tokens.size();
    end

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import csvt_pkg::*;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    bit          calm = 1'b0;
    int          stall_left = 0;
    int          item_count = 0;
    logic [7:0]  rec_bytes[$];

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    csv_field_tokenizer_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    csvt_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    always @(posedge clk) begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic has, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (has || last)
            item_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // sends the collected record bytes, optionally closed by a byteless item
    task automatic send_record(input bit byteless_close);
        for (int i = 0; i < rec_bytes.size(); i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(rec_bytes[i], 1'b1, (i == rec_bytes.size() - 1) && !byteless_close);
        end
        if (byteless_close || rec_bytes.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        rec_bytes.delete();
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 3))
            0: return CH_QUOTE;
            1: return CH_COMMA;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            rec_bytes.insert(rec_bytes.size(), s[i]);
    endfunction

    function automatic void build_good_record();
        int nfields;
        int len;
        logic [7:0] b;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                rec_bytes.insert(rec_bytes.size(), CH_COMMA);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0) begin
                rec_bytes.insert(rec_bytes.size(), CH_QUOTE);
                for (int i = 0; i < len; i++) begin
                    b = ($urandom_range(0, 2) == 0) ? special_byte() : 8'($urandom_range(0, 255));
                    rec_bytes.insert(rec_bytes.size(), b);
                    if (b == CH_QUOTE)
                        rec_bytes.insert(rec_bytes.size(), CH_QUOTE);
                end
                rec_bytes.insert(rec_bytes.size(), CH_QUOTE);
            end else begin
                for (int i = 0; i < len; i++)
                    rec_bytes.insert(rec_bytes.size(), plain_byte());
            end
        end
    endfunction

    function automatic void break_record();
        int pos;
        pos = $urandom_range(0, rec_bytes.size());
        case ($urandom_range(0, 4))
            0: rec_bytes.insert(pos, CH_CR);
            1: rec_bytes.insert(pos, CH_LF);
            2: rec_bytes.insert(pos, CH_QUOTE);
            3: rec_bytes.insert(pos, plain_byte());
            default: if (rec_bytes.size() > 0) rec_bytes.delete(rec_bytes.size() - 1);
        endcase
    endfunction

    function automatic void build_noise_record();
        int len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
            rec_bytes.insert(rec_bytes.size(), $urandom_range(0, 1) ? special_byte()
                                                : 8'($urandom_range(0, 255)));
    endfunction

    initial begin
        int r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty record
        send_record(1'b0);
        // two plain fields, idle item ahead
        send_item(8'h5A, 1'b0, 1'b0);
        push_text("a,b");
        send_record(1'b0);
        // doubled quote, quote still held at the record end
        push_text("\"\"\"\"");
        send_record(1'b0);
        // line break inside quotes, held quote closed by comma, bare lf at the end
        rec_bytes.insert(rec_bytes.size(), CH_QUOTE);
        rec_bytes.insert(rec_bytes.size(), CH_CR);
        rec_bytes.insert(rec_bytes.size(), CH_QUOTE);
        rec_bytes.insert(rec_bytes.size(), CH_COMMA);
        rec_bytes.insert(rec_bytes.size(), CH_LF);
        send_record(1'b0);
        // bare cr mid record, rest discarded
        rec_bytes.insert(rec_bytes.size(), CH_CR);
        rec_bytes.insert(rec_bytes.size(), 8'hFF);
        send_record(1'b0);
        // misplaced quote
        push_text("a\"");
        send_record(1'b0);
        // data after the closing quote
        push_text("\"a\"b");
        send_record(1'b0);
        // unterminated quote
        push_text("\"a");
        send_record(1'b0);
        // extreme byte values, closed by a byteless item
        rec_bytes.insert(rec_bytes.size(), 8'h00);
        rec_bytes.insert(rec_bytes.size(), 8'hFF);
        send_record(1'b1);
        wait_drained();

        item_count = 0;
        while (item_count < 550) begin
            calm = ($urandom_range(0, 6) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                build_good_record();
            end else if (r < 80) begin
                build_good_record();
                break_record();
            end else if (r < 95) begin
                build_noise_record();
            end
            send_record($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
